>>> design/xrg_pkg.sv
`default_nettype none
package xrg_pkg;

   localparam int DataWidth = 32;
   localparam int ShiftA = 13;
   localparam int ShiftB = 17;
   localparam int ShiftC = 5;
   localparam logic [DataWidth-1:0] SeedReset = 32'd1;

   localparam logic OpRaw = 1'b0;
   localparam logic OpRange = 1'b1;

   localparam int QueueDepth = 2;
   localparam int QueueAddrWidth = $clog2(QueueDepth);
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   localparam int DivCountWidth = $clog2(DataWidth);
   localparam logic [DivCountWidth-1:0] DivLast = DivCountWidth'(DataWidth - 1);

   // One classified request as it waits between the front and back ends.
   typedef struct packed {
      logic                 need_div;
      logic                 zero_mod;
      logic [DataWidth-1:0] range_low;
      logic [DataWidth-1:0] modulus;
      logic [DataWidth-1:0] raw;
   } entry_type;

   function automatic logic [DataWidth-1:0] advance(input logic [DataWidth-1:0] x);
      logic [DataWidth-1:0] a;
      logic [DataWidth-1:0] b;
      a = x ^ (x << ShiftA);
      b = a ^ (a >> ShiftB);
      return b ^ (b << ShiftC);
   endfunction

endpackage
`default_nettype wire

>>> design/xorshift32_range_generator_top.sv
// Xorshift32 random number generator (shifts 13, 17, 5) with an optional reduction of
// each new value into the range (low, high]. Every accepted request word advances the
// state once; writing the seed register reloads the state, and reset loads the seed 1.
// Raw requests and requests whose range is empty (high equal to low) skip the division;
// range requests pass through a bit-serial remainder unit that retires one quotient bit
// per cycle. A two-word queue sits between the request front end and that unit, so
// requests are still taken while a division is under way, until the queue is full.
`default_nettype none
module xorshift32_range_generator_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [xrg_pkg::DataWidth-1:0] csr_wdata,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_opcode,
   input  wire logic [xrg_pkg::DataWidth-1:0] req_range_low,
   input  wire logic [xrg_pkg::DataWidth-1:0] req_range_high,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [xrg_pkg::DataWidth-1:0]      rsp_value,
   output logic [xrg_pkg::DataWidth-1:0]      rsp_raw_state,
   output logic                               rsp_zero_modulus
);

   xrg_pkg::entry_type push_entry;
   xrg_pkg::entry_type head_entry;
   logic               q_push;
   logic               q_pop;
   logic               q_full;
   logic               q_empty;

   xrg_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_entry        (push_entry)
   );

   xrg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   xrg_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_head           (head_entry),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value        (rsp_value),
      .rsp_raw_state    (rsp_raw_state),
      .rsp_zero_modulus (rsp_zero_modulus)
   );

endmodule
`default_nettype wire

>>> design/xrg_front.sv
`default_nettype none
module xrg_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [xrg_pkg::DataWidth-1:0]     csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_opcode,
   input  wire logic [xrg_pkg::DataWidth-1:0]     req_range_low,
   input  wire logic [xrg_pkg::DataWidth-1:0]     req_range_high,
   input  wire logic                              q_full,
   output logic                                   q_push,
   output xrg_pkg::entry_type                     q_entry
);

   logic [xrg_pkg::DataWidth-1:0] state_ff;
   logic [xrg_pkg::DataWidth-1:0] state_in;
   logic [xrg_pkg::DataWidth-1:0] next_state;
   logic [xrg_pkg::DataWidth-1:0] modulus;
   logic                          is_range;
   logic                          mod_zero;

   assign req_stall  = q_full;
   assign q_push     = req_valid & ~q_full;
   assign next_state = xrg_pkg::advance(state_ff);
   assign modulus    = req_range_high - req_range_low;
   assign is_range   = (req_opcode == xrg_pkg::OpRange);
   assign mod_zero   = (modulus == '0);

   always_comb begin
      q_entry.need_div  = is_range & ~mod_zero;
      q_entry.zero_mod  = is_range & mod_zero;
      q_entry.range_low = req_range_low;
      q_entry.modulus   = modulus;
      q_entry.raw       = next_state;
   end

   // A seed write reloads the generator; the user must write it only while the block is idle (not enforced here).
   always_comb begin
      state_in = state_ff;
      if (csr_we) begin
         state_in = csr_wdata;
      end else if (q_push) begin
         state_in = next_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xrg_pkg::SeedReset;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

>>> design/xrg_queue.sv
`default_nettype none
module xrg_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire xrg_pkg::entry_type push_entry,
   input  wire logic               pop,
   output xrg_pkg::entry_type      head_entry,
   output logic                    full,
   output logic                    empty
);

   xrg_pkg::entry_type entries [xrg_pkg::QueueDepth];

   logic [xrg_pkg::QueueAddrWidth-1:0]  wr_ptr_ff;
   logic [xrg_pkg::QueueAddrWidth-1:0]  wr_ptr_in;
   logic [xrg_pkg::QueueAddrWidth-1:0]  rd_ptr_ff;
   logic [xrg_pkg::QueueAddrWidth-1:0]  rd_ptr_in;
   logic [xrg_pkg::QueueCountWidth-1:0] count_ff;
   logic [xrg_pkg::QueueCountWidth-1:0] count_in;
   logic                                do_push;
   logic                                do_pop;

   assign full       = (count_ff == xrg_pkg::QueueCountWidth'(xrg_pkg::QueueDepth));
   assign empty      = (count_ff == '0);
   assign do_push    = push & ~full;
   assign do_pop     = pop & ~empty;
   assign head_entry = entries[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == xrg_pkg::QueueAddrWidth'(xrg_pkg::QueueDepth - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == xrg_pkg::QueueAddrWidth'(xrg_pkg::QueueDepth - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

>>> design/xrg_back.sv
`default_nettype none
module xrg_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_empty,
   input  wire xrg_pkg::entry_type            q_head,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [xrg_pkg::DataWidth-1:0]      rsp_value,
   output logic [xrg_pkg::DataWidth-1:0]      rsp_raw_state,
   output logic                               rsp_zero_modulus
);

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StDiv  = 2'd1;
   localparam logic [1:0] StFin  = 2'd2;

   logic [1:0]                           state_ff;
   logic [1:0]                           state_in;
   xrg_pkg::entry_type                   entry_ff;
   xrg_pkg::entry_type                   entry_in;
   logic [xrg_pkg::DataWidth-1:0]        rem_ff;
   logic [xrg_pkg::DataWidth-1:0]        rem_in;
   logic [xrg_pkg::DataWidth-1:0]        dvd_ff;
   logic [xrg_pkg::DataWidth-1:0]        dvd_in;
   logic [xrg_pkg::DivCountWidth-1:0]    cnt_ff;
   logic [xrg_pkg::DivCountWidth-1:0]    cnt_in;
   logic [xrg_pkg::DataWidth:0]          rem_shift;
   logic [xrg_pkg::DataWidth:0]          rem_diff;
   logic                                 load;
   logic [xrg_pkg::DataWidth-1:0]        result;
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic [xrg_pkg::DataWidth-1:0]        value_ff;
   logic [xrg_pkg::DataWidth-1:0]        raw_ff;
   logic                                 zero_ff;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   assign rem_shift = {rem_ff, dvd_ff[xrg_pkg::DataWidth-1]};
   assign rem_diff  = rem_shift - {1'b0, entry_ff.modulus};

   always_comb begin
      state_in = state_ff;
      entry_in = entry_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      cnt_in   = cnt_ff;
      q_pop    = 1'b0;
      load     = 1'b0;
      unique case (state_ff)
         StIdle: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               entry_in = q_head;
               rem_in   = '0;
               dvd_in   = q_head.raw;
               cnt_in   = '0;
               state_in = q_head.need_div ? StDiv : StFin;
            end
         end
         StDiv: begin
            rem_in = rem_diff[xrg_pkg::DataWidth]
                     ? rem_shift[xrg_pkg::DataWidth-1:0]
                     : rem_diff[xrg_pkg::DataWidth-1:0];
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == xrg_pkg::DivLast) begin
               state_in = StFin;
            end
         end
         StFin: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load     = 1'b1;
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_comb begin
      if (entry_ff.need_div) begin
         result = rem_ff + entry_ff.range_low + xrg_pkg::DataWidth'(1);
      end else if (entry_ff.zero_mod) begin
         result = '0;
      end else begin
         result = entry_ff.raw;
      end
   end

   assign rsp_valid_in = load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      cnt_ff   <= cnt_in;
      if (load) begin
         value_ff <= result;
         raw_ff   <= entry_ff.raw;
         zero_ff  <= entry_ff.zero_mod;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value        = value_ff;
   assign rsp_raw_state    = raw_ff;
   assign rsp_zero_modulus = zero_ff;

endmodule
`default_nettype wire

>>> design/xrg_checker.sv
`default_nettype none
module xrg_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          csr_we,
   input wire logic [xrg_pkg::DataWidth-1:0] csr_wdata,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          req_opcode,
   input wire logic [xrg_pkg::DataWidth-1:0] req_range_low,
   input wire logic [xrg_pkg::DataWidth-1:0] req_range_high,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [xrg_pkg::DataWidth-1:0] rsp_value,
   input wire logic [xrg_pkg::DataWidth-1:0] rsp_raw_state,
   input wire logic                          rsp_zero_modulus
);

   // Nothing is pending after reset, so no result word shows and the queue is open.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("result or stall present after reset");

   // An empty range always reports a zero value.
   a_zero_mod_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_modulus |-> rsp_value == '0)
      else $error("zero modulus with nonzero value");

   // Handshakes are always known, and so is any word offered on a channel.
   a_no_unknown: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_valid, req_stall, rsp_valid, rsp_stall, csr_we})
      && (!req_valid || !$isunknown({req_opcode, req_range_low, req_range_high}))
      && (!csr_we || !$isunknown(csr_wdata))
      && (!rsp_valid || !$isunknown({rsp_value, rsp_raw_state, rsp_zero_modulus})))
      else $error("unknown value on a handshake or an offered word");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value)
         && $stable(rsp_raw_state) && $stable(rsp_zero_modulus))
      else $error("stalled result word changed");

endmodule

bind xorshift32_range_generator_top xrg_checker u_xrg_checker (.*);
`default_nettype wire

>>> sim/xorshift32_range_generator_top_test.sv
`timescale 1ns / 100ps
module xorshift32_range_generator_top_test;

   localparam int CycleLimit = 600000;
   localparam int HoldCycles = 400;
   localparam int SettleCycles = 40;
   localparam int PhaseWords = 200;

   typedef logic [xrg_pkg::DataWidth-1:0] word_type;

   typedef struct {
      word_type value;
      word_type raw_state;
      logic     zero_modulus;
   } draw_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     csr_we = 1'b0;
   word_type csr_wdata = '0;
   logic     req_valid = 1'b0;
   logic     req_opcode = xrg_pkg::OpRaw;
   word_type req_range_low = '0;
   word_type req_range_high = '0;
   logic     rsp_stall = 1'b0;
   wire logic     req_stall;
   wire logic     rsp_valid;
   wire word_type rsp_value;
   wire word_type rsp_raw_state;
   wire logic     rsp_zero_modulus;

   // Generator state as this side expects it, and the draws still owed by the block.
   word_type gen_state = xrg_pkg::SeedReset;
   draw_type pending_draws[$];

   int send_idle_pct = 0;
   int stall_idle_pct = 0;
   bit hold_start = 1'b0;
   int hold_left = 0;

   int cycle_count = 0;
   int error_count = 0;
   int words_sent = 0;
   int range_words = 0;
   int results_checked = 0;
   int empty_ranges_seen = 0;
   int seeds_written = 0;

   xorshift32_range_generator_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_range_low    (req_range_low),
      .req_range_high   (req_range_high),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value        (rsp_value),
      .rsp_raw_state    (rsp_raw_state),
      .rsp_zero_modulus (rsp_zero_modulus)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("Timeout after %0d cycles with %0d words outstanding",
                  cycle_count, pending_draws.size());
         $display("xorshift32_range_generator_top verification failed");
         $finish;
      end
   end

   // Receiver: random stall, or a long hold-off once a test asks for one.
   always @(negedge clock) begin
      if (hold_start) begin
         hold_left = HoldCycles;
         hold_start = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_idle_pct);
      end
   end

   task automatic report_mismatch(input string what, input word_type got,
                                  input word_type want);
      $display("MISMATCH cycle %0d: %s got %h, expected %h", cycle_count, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin : check_results
      draw_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_draws.size() == 0) begin
            report_mismatch("unexpected result word, value", rsp_value, '0);
         end else begin
            want = pending_draws.pop_front();
            results_checked++;
            if (rsp_value !== want.value)
               report_mismatch("value", rsp_value, want.value);
            if (rsp_raw_state !== want.raw_state)
               report_mismatch("raw_state", rsp_raw_state, want.raw_state);
            if (rsp_zero_modulus !== want.zero_modulus)
               report_mismatch("zero_modulus", word_type'(rsp_zero_modulus),
                               word_type'(want.zero_modulus));
            if (want.zero_modulus)
               empty_ranges_seen++;
         end
      end
   end

   function automatic word_type xorshift_next(input word_type s);
      word_type t;
      t = s ^ (s << 13);
      t = t ^ (t >> 17);
      return t ^ (t << 5);
   endfunction

   // Advances the local state and queues the draw the block owes for this word.
   task automatic predict_draw(input logic op, input word_type lo, input word_type hi);
      draw_type d;
      word_type span;
      gen_state = xorshift_next(gen_state);
      span = hi - lo;
      d.raw_state = gen_state;
      d.value = gen_state;
      d.zero_modulus = 1'b0;
      if (op == xrg_pkg::OpRange) begin
         range_words++;
         if (span == '0) begin
            d.zero_modulus = 1'b1;
            d.value = '0;
         end else begin
            d.value = (gen_state % span) + lo + word_type'(1);
         end
      end
      pending_draws.push_back(d);
   endtask

   task automatic send_word(input logic op, input word_type lo, input word_type hi);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 60)
         gap++;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_range_low <= lo;
      req_range_high <= hi;
      do @(posedge clock); while (req_stall);
      words_sent++;
      predict_draw(op, lo, hi);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_draws.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_seed(input word_type seed);
      wait_for_results();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= seed;
      @(posedge clock);
      gen_state = seed;
      seeds_written++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic pick_range(output word_type lo, output word_type hi);
      lo = $urandom;
      case ($urandom_range(9))
         0: hi = lo;
         1: begin
            hi = $urandom;
            if (hi > lo) {lo, hi} = {hi, lo};
         end
         2: hi = lo + word_type'($urandom_range(1, 16));
         3: begin
            lo = '0;
            hi = '1;
         end
         4: hi = $urandom;
         5: begin
            lo = '1 - word_type'($urandom_range(0, 7));
            hi = word_type'($urandom_range(0, 7));
         end
         default: hi = lo + ($urandom >> $urandom_range(0, 31));
      endcase
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      stall_idle_pct = 0;
      send_word(xrg_pkg::OpRaw, '0, '0);
      send_word(xrg_pkg::OpRaw, '1, '1);
      send_word(xrg_pkg::OpRaw, 32'h5555_5555, 32'hAAAA_AAAA);
      send_word(xrg_pkg::OpRange, '0, '1);
      send_word(xrg_pkg::OpRange, '1, '0);
      send_word(xrg_pkg::OpRange, '0, '0);
      send_word(xrg_pkg::OpRange, '1, '1);
      send_word(xrg_pkg::OpRange, 32'd1000, 32'd1001);
      send_word(xrg_pkg::OpRange, 32'd0, 32'd1);
      send_word(xrg_pkg::OpRange, 32'd10, 32'd16);
      send_word(xrg_pkg::OpRange, 32'd100, 32'd50);
      send_word(xrg_pkg::OpRange, 32'd0, 32'h8000_0000);
      send_word(xrg_pkg::OpRange, 32'h8000_0000, 32'h0000_0000);
      send_word(xrg_pkg::OpRange, 32'h0000_0000, 32'h0001_0000);
      send_word(xrg_pkg::OpRange, 32'hFFFF_FFF0, 32'h0000_0010);
      send_word(xrg_pkg::OpRange, 32'h1234_5678, 32'h1234_5678);
      send_word(xrg_pkg::OpRaw, 32'hFFFF_0000, 32'h0000_FFFF);
      send_word(xrg_pkg::OpRange, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      wait_for_results();
   endtask

   // A zero seed sticks the generator at zero; the all-ones seed is the other extreme.
   task automatic test_seed_extremes();
      write_seed('0);
      send_word(xrg_pkg::OpRaw, '0, '0);
      send_word(xrg_pkg::OpRange, '0, 32'd7);
      send_word(xrg_pkg::OpRange, 32'd5, 32'd5);
      send_word(xrg_pkg::OpRange, '1, '0);
      write_seed('1);
      send_word(xrg_pkg::OpRaw, '0, '0);
      send_word(xrg_pkg::OpRange, '0, '1);
      send_word(xrg_pkg::OpRange, 32'd3, 32'd2);
      send_word(xrg_pkg::OpRaw, '1, '1);
      write_seed(xrg_pkg::SeedReset);
      send_word(xrg_pkg::OpRaw, '0, '0);
      wait_for_results();
   endtask

   // The receiver holds off while words keep coming, so the block's queue fills up.
   task automatic test_backpressure();
      word_type lo;
      word_type hi;
      send_idle_pct = 0;
      stall_idle_pct = 0;
      @(posedge clock);
      hold_start = 1'b1;
      repeat (12) begin
         pick_range(lo, hi);
         send_word(1'($urandom_range(1)), lo, hi);
      end
      wait_for_results();
   endtask

   task automatic test_random_phase(input int send_pct, input int stall_pct,
                                    input word_type seed);
      word_type lo;
      word_type hi;
      write_seed(seed);
      send_idle_pct = send_pct;
      stall_idle_pct = stall_pct;
      repeat (PhaseWords) begin
         pick_range(lo, hi);
         send_word(1'($urandom_range(1)), lo, hi);
      end
      wait_for_results();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_seed_extremes();
      test_backpressure();
      test_random_phase(0, 0, $urandom);
      test_random_phase(78, 0, 32'h8000_0000);
      test_random_phase(0, 78, $urandom);
      test_random_phase(18, 18, $urandom);
      send_idle_pct = 0;
      stall_idle_pct = 0;
      wait_for_results();
      repeat (SettleCycles) @(posedge clock);
      if (pending_draws.size() != 0)
         report_mismatch("results left over", word_type'(pending_draws.size()), '0);
      $display("Sent %0d request words (%0d range requests) over %0d seed writes.",
               words_sent, range_words, seeds_written);
      $display("Checked %0d result words, %0d with an empty range, across all idle mixes.",
               results_checked, empty_ranges_seen);
      if (error_count == 0) begin
         $display("xorshift32_range_generator_top verification clean");
      end else begin
         $display("xorshift32_range_generator_top verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/xrg_pkg.sv
design/xrg_front.sv
design/xrg_queue.sv
design/xrg_back.sv
design/xorshift32_range_generator_top.sv
design/xrg_checker.sv
sim/xorshift32_range_generator_top_test.sv
